/* sv/gec_pkg.sv */
// ----------------------------------------------------------------------------
// gec_pkg: shared constants and types of the greedy edge colorer
// Sizes of the edge store, field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
package gec_pkg;

  localparam int MAX_EDGES   = 32;  // edges held per graph
  localparam int VERTEX_BITS = 8;   // endpoint bits used in compares

  localparam int VTX_W     = 8;     // width of the vertex fields at the port
  localparam int IDX_OUT_W = 5;     // edge_index field width
  localparam int COLOR_W   = 6;     // edge_color / colors_used field width

  localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;  // store address
  localparam int CNT_W = $clog2(MAX_EDGES + 1);                    // count 0..MAX, colors

  // commands from the controller to the datapath
  typedef struct packed {
    logic             ld_we;      // store incoming edge
    logic [IDX_W-1:0] ld_addr;
    logic [IDX_W-1:0] rd_addr;    // shared read address of both stores
    logic             latch;      // capture current edge, clear taken set
    logic             scan;       // read issued for an earlier edge
    logic             pick;       // write lowest free color of current edge
    logic [IDX_W-1:0] pick_addr;
    logic             top_clr;    // new graph: clear highest color
    logic             emit;       // load output register
    logic [IDX_W-1:0] emit_idx;
    logic             emit_last;
  } gec_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic out_free;               // output register can take a result
  } gec_sts_t;

endpackage

/* sv/gec_ctl.sv */
// ----------------------------------------------------------------------------
// gec_ctl: sequencer of the greedy edge colorer
// Loads edges, walks each edge against all earlier ones, then emits results.
// ----------------------------------------------------------------------------
module gec_ctl
  import gec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_edge,
  output logic     in_ready,
  input  gec_sts_t sts,
  output gec_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_FETCH   = 8'b0000_0010,
    S_LATCH   = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_DRAIN   = 8'b0001_0000,
    S_PICK    = 8'b0010_0000,
    S_EMIT_RD = 8'b0100_0000,
    S_EMIT_LD = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // edges stored
  logic [CNT_W-1:0] n_r, n_nxt;         // edges in graph being colored
  logic [IDX_W-1:0] i_r, i_nxt;         // edge being colored
  logic [IDX_W-1:0] j_r, j_nxt;         // earlier edge being read
  logic [IDX_W-1:0] k_r, k_nxt;         // result being emitted
  logic             has_room;

  assign has_room = (cnt_r < CNT_W'(MAX_EDGES));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.ld_addr   = cnt_r[IDX_W-1:0];
    cmd.pick_addr = i_r;
    cmd.emit_idx  = k_r;
    cmd.rd_addr   = i_r;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (has_room) begin
            cmd.ld_we = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (in_last_edge) begin
            n_nxt       = has_room ? cnt_r + CNT_W'(1) : cnt_r;
            i_nxt       = '0;
            cmd.top_clr = 1'b1;
            state_nxt   = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch = 1'b1;
        if (i_r == '0) begin
          state_nxt = S_PICK;
        end else begin
          j_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_addr = j_r;
        cmd.scan    = 1'b1;
        if (j_r == i_r - IDX_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        if (CNT_W'(i_r) + CNT_W'(1) == n_r) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_FETCH;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_addr = k_r;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.rd_addr   = k_r;
        cmd.emit_last = (CNT_W'(k_r) + CNT_W'(1) == n_r);
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cmd.emit_last) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // store never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_EDGES))
    else $error("edge count above capacity");

  // only earlier edges are scanned
  a_scan_earlier: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> j_r < i_r)
    else $error("scan index not below current edge");

  // coloring stays inside the graph
  a_pick_in_graph: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PICK |-> CNT_W'(i_r) < n_r)
    else $error("colored edge beyond graph size");

  // emission stays inside the graph
  a_emit_in_graph: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_LD |-> CNT_W'(k_r) < n_r)
    else $error("emitted edge beyond graph size");

  // a graph being colored is never empty
  a_graph_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> n_r != '0)
    else $error("coloring an empty graph");

endmodule

/* sv/gec_dp.sv */
// ----------------------------------------------------------------------------
// gec_dp: datapath of the greedy edge colorer
// Edge and color stores, adjacency compare, taken set, output register.
// ----------------------------------------------------------------------------
module gec_dp
  import gec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  gec_cmd_t             cmd,
  output gec_sts_t             sts,
  input  logic [VTX_W-1:0]     in_vertex_a,
  input  logic [VTX_W-1:0]     in_vertex_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_OUT_W-1:0] out_edge_index,
  output logic [COLOR_W-1:0]   out_edge_color,
  output logic [COLOR_W-1:0]   out_colors_used,
  output logic                 out_last_result
);

  logic [2*VERTEX_BITS-1:0] ep_mem [MAX_EDGES];
  logic [CNT_W-1:0]         color_mem [MAX_EDGES];

  logic [2*VERTEX_BITS-1:0] rd_ep_r;
  logic [CNT_W-1:0]         rd_color_r;
  logic [VERTEX_BITS-1:0]   cur_a_r, cur_b_r;
  logic [VERTEX_BITS-1:0]   rd_a, rd_b;
  logic                     scan_vld_r;
  logic [MAX_EDGES:0]       taken_r, taken_nxt;
  logic [CNT_W-1:0]         top_r, top_nxt;
  logic [CNT_W-1:0]         pick_c;
  logic                     touch;

  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0]     out_idx_r;
  logic [COLOR_W-1:0]       out_color_r;
  logic [COLOR_W-1:0]       out_used_r;
  logic                     out_last_r;

  // edge store: write on load, one registered read
  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      ep_mem[cmd.ld_addr] <= {in_vertex_a[VERTEX_BITS-1:0], in_vertex_b[VERTEX_BITS-1:0]};
    end
    rd_ep_r <= ep_mem[cmd.rd_addr];
  end

  // color store
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      color_mem[cmd.pick_addr] <= pick_c;
    end
    rd_color_r <= color_mem[cmd.rd_addr];
  end

  assign rd_a  = rd_ep_r[2*VERTEX_BITS-1:VERTEX_BITS];
  assign rd_b  = rd_ep_r[VERTEX_BITS-1:0];
  assign touch = (cur_a_r == rd_a) || (cur_a_r == rd_b) ||
                 (cur_b_r == rd_a) || (cur_b_r == rd_b);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_a_r <= rd_a;
      cur_b_r <= rd_b;
    end
  end

  // lowest color not in the taken set
  always_comb begin
    pick_c = CNT_W'(MAX_EDGES);
    for (int c = MAX_EDGES; c >= 1; c--) begin
      if (!taken_r[c]) begin
        pick_c = CNT_W'(c);
      end
    end
  end

  always_comb begin
    taken_nxt = taken_r;
    if (cmd.latch) begin
      taken_nxt = '0;
    end else if (scan_vld_r && touch) begin
      taken_nxt[rd_color_r] = 1'b1;
    end
  end

  always_comb begin
    top_nxt = top_r;
    if (cmd.top_clr) begin
      top_nxt = '0;
    end else if (cmd.pick && pick_c > top_r) begin
      top_nxt = pick_c;
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // highest color is held with the result: a new graph may clear top_r
  // while the last result still waits
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r   <= IDX_OUT_W'(cmd.emit_idx);
      out_color_r <= COLOR_W'(rd_color_r);
      out_used_r  <= COLOR_W'(top_r);
      out_last_r  <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r  <= 1'b0;
      taken_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_vld_r  <= cmd.scan;
      taken_r     <= taken_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edge_index  = out_idx_r;
  assign out_edge_color  = out_color_r;
  assign out_colors_used = out_used_r;
  assign out_last_result = out_last_r;

  // a picked color is never zero
  a_pick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |-> pick_c != '0)
    else $error("picked color zero");

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten");

  // color zero never enters the taken set
  a_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !taken_r[0])
    else $error("color zero marked taken");

endmodule

/* sv/greedy_edge_colorer_top.sv */
// ----------------------------------------------------------------------------
// greedy_edge_colorer_top: greedy edge colorer
// Load: one edge request per cycle. After the final edge, each edge i is
//   colored by fetch, latch, one read per earlier edge, drain and pick (edge 0
//   skips reads and drain); reads go through the single edge store read port.
//   Results then leave one at a time, each loaded when the output is free.
// Reset (rst_n low, synchronous) empties the edge count and output register.
// ----------------------------------------------------------------------------
module greedy_edge_colorer_top
  import gec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // edge requests
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VTX_W-1:0]     in_vertex_a,
  input  logic [VTX_W-1:0]     in_vertex_b,
  input  logic                 in_last_edge,
  // color results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_OUT_W-1:0] out_edge_index,
  output logic [COLOR_W-1:0]   out_edge_color,
  output logic [COLOR_W-1:0]   out_colors_used,
  output logic                 out_last_result
);

  // Edges beyond capacity are dropped; a final edge still starts coloring.
  // Adjacency: any endpoint of one edge equals any endpoint of the other,
  // which covers self loops and repeated edges.
  // The block returns to loading as soon as the last result sits in the
  // output register, so a new graph can start while it waits to be taken.

  gec_cmd_t cmd;
  gec_sts_t sts;

  gec_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_edge (in_last_edge),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  gec_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_edge_index  (out_edge_index),
    .out_edge_color  (out_edge_color),
    .out_colors_used (out_colors_used),
    .out_last_result (out_last_result)
  );

endmodule
